// ===== hw/rtl/frn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the feature running normalizer.
// No dependencies; imported by every module of the block.
package frn_pkg;

  localparam int NUM_FEATURES_DEF = 13;

  localparam int COEFF_W  = 20;   // Q10.10 input
  localparam int MEAN_W   = 24;   // Q14.10 mean and smoothed state
  localparam int VAR_W    = 48;   // Q28.20 variance
  localparam int WEIGHT_W = 16;   // Q0.16 weights
  localparam int OUT_W    = 16;   // Q6.10 result
  localparam int POS_W    = 4;
  localparam int FRAC_W   = 10;

  localparam int MAG_W  = 24;               // |x - mean|
  localparam int NUM_W  = MAG_W + FRAC_W;   // dividend
  localparam int ROOT_W = 25;               // floor(sqrt(var + 1))
  localparam int RAD_W  = 2 * ROOT_W;       // radicand, padded to an even width

  localparam logic [WEIGHT_W-1:0] STATS_WEIGHT_RST  = 16'd64225;
  localparam logic [WEIGHT_W-1:0] SMOOTH_WEIGHT_RST = 16'd55706;
  localparam logic [VAR_W-1:0]    VAR_ONE           = 48'd1048576;

  typedef enum logic {
    CFG_STATS_WEIGHT  = 1'b0,
    CFG_SMOOTH_WEIGHT = 1'b1
  } cfg_index_t;

  // Clamp a rounded Q.10 value to the 24-bit state range.
  function automatic logic signed [MEAN_W-1:0] sat_q24(input logic signed [26:0] v);
    if (v > 27'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -27'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[MEAN_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/frn_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, with a sideband bus.
// Depends on frn_pkg for the default radicand width.
module frn_sqrt import frn_pkg::*; #(
  parameter int IN_W = RAD_W,
  parameter int SB_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SB_W-1:0]     in_sb,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SB_W-1:0]     out_sb
);

  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 3;

  logic [RW-1:0]    vld;
  logic [REM_W-1:0] rem      [RW];
  logic [RW-1:0]    rt       [RW];
  logic [IN_W-1:0]  rad      [RW];
  logic [SB_W-1:0]  sb       [RW];
  logic [REM_W-1:0] rem_in   [RW];
  logic [RW-1:0]    rt_in    [RW];
  logic [IN_W-1:0]  rad_in   [RW];
  logic [REM_W-1:0] rem_next [RW];
  logic [RW-1:0]    rt_next  [RW];
  logic [IN_W-1:0]  rad_next [RW];

  always_comb begin
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    rem_in[0] = '0;
    rt_in[0]  = '0;
    rad_in[0] = radicand;
    for (int i = 1; i < RW; i++) begin
      rem_in[i] = rem[i-1];
      rt_in[i]  = rt[i-1];
      rad_in[i] = rad[i-1];
    end
    for (int i = 0; i < RW; i++) begin
      cur   = {rem_in[i][REM_W-3:0], rad_in[i][IN_W-1 -: 2]};
      trial = REM_W'({rt_in[i], 2'b01});
      if (cur >= trial) begin
        rem_next[i] = cur - trial;
        rt_next[i]  = {rt_in[i][RW-2:0], 1'b1};
      end else begin
        rem_next[i] = cur;
        rt_next[i]  = {rt_in[i][RW-2:0], 1'b0};
      end
      rad_next[i] = rad_in[i] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= in_sb;
      for (int i = 1; i < RW; i++) begin
        sb[i] <= sb[i-1];
      end
      for (int i = 0; i < RW; i++) begin
        rem[i] <= rem_next[i];
        rt[i]  <= rt_next[i];
        rad[i] <= rad_next[i];
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign out_sb    = sb[RW-1];

endmodule

// ===== hw/rtl/frn_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, one quotient bit per stage, with sideband.
// Depends on frn_pkg for the default operand widths.
module frn_div import frn_pkg::*; #(
  parameter int N_W  = NUM_W,
  parameter int D_W  = ROOT_W,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    dividend,
  input  logic [D_W-1:0]    divisor,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [N_W-1:0]    quotient,
  output logic [SB_W-1:0]   out_sb
);

  logic [N_W-1:0]  vld;
  logic [D_W-1:0]  rem      [N_W];
  logic [N_W-1:0]  q        [N_W];
  logic [N_W-1:0]  num      [N_W];
  logic [D_W-1:0]  den      [N_W];
  logic [SB_W-1:0] sb       [N_W];
  logic [D_W-1:0]  rem_in   [N_W];
  logic [N_W-1:0]  q_in     [N_W];
  logic [N_W-1:0]  num_in   [N_W];
  logic [D_W-1:0]  den_in   [N_W];
  logic [D_W-1:0]  rem_next [N_W];
  logic [N_W-1:0]  q_next   [N_W];

  always_comb begin
    logic [D_W:0] cur;
    logic [D_W:0] dext;
    rem_in[0] = '0;
    q_in[0]   = '0;
    num_in[0] = dividend;
    den_in[0] = divisor;
    for (int i = 1; i < N_W; i++) begin
      rem_in[i] = rem[i-1];
      q_in[i]   = q[i-1];
      num_in[i] = num[i-1];
      den_in[i] = den[i-1];
    end
    for (int i = 0; i < N_W; i++) begin
      cur  = {rem_in[i], num_in[i][N_W-1]};
      dext = {1'b0, den_in[i]};
      if (cur >= dext) begin
        rem_next[i] = D_W'(cur - dext);
        q_next[i]   = {q_in[i][N_W-2:0], 1'b1};
      end else begin
        rem_next[i] = cur[D_W-1:0];
        q_next[i]   = {q_in[i][N_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= in_sb;
      for (int i = 1; i < N_W; i++) begin
        sb[i] <= sb[i-1];
      end
      for (int i = 0; i < N_W; i++) begin
        rem[i] <= rem_next[i];
        q[i]   <= q_next[i];
        num[i] <= num_in[i] << 1;
        den[i] <= den_in[i];
      end
    end
  end

  assign out_valid = vld[N_W-1];
  assign quotient  = q[N_W-1];
  assign out_sb    = sb[N_W-1];

endmodule

// ===== hw/rtl/feature_running_normalizer.sv =====
`timescale 1ns / 1ps
// Top level: EWMA mean/variance feature normalizer with output smoothing.
// Depends on frn_pkg, frn_sqrt and frn_div.
//
//  channel  signals                                         direction
//  coeff    coeff_valid, coeff_stall, coeff                 in (stall out)
//  result   result_valid, result_stall, smoothed_value,
//           position, frame_end                             out (stall in)
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data       in (ready out)
//
// One coefficient per cycle while no result waits under result_stall; the pipeline
// runs stages 1 to 5, the root stages (one bit each), the divider stages and A to C.
// The whole pipeline advances together: it holds only while a result waits
// under result_stall. Reset clears valids, frame counter and first-frame flag;
// per-position stores are written during the first frame before any read.
module feature_running_normalizer import frn_pkg::*; #(
  parameter int NUM_FEATURES = NUM_FEATURES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       coeff_valid,
  output logic                       coeff_stall,
  input  logic signed [COEFF_W-1:0]  coeff,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [OUT_W-1:0]    smoothed_value,
  output logic [POS_W-1:0]           position,
  output logic                       frame_end,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [WEIGHT_W-1:0]        cfg_data
);

  localparam int PW      = $clog2(NUM_FEATURES);
  localparam int SB_SQ_W = COEFF_W + PW + 3 + MAG_W;
  localparam int SB_DV_W = COEFF_W + PW + 3;
  localparam logic [PW-1:0] LAST_POS = PW'(NUM_FEATURES - 1);

  // configuration
  logic [WEIGHT_W-1:0] stats_weight;
  logic [WEIGHT_W-1:0] smooth_weight;
  logic [WEIGHT_W:0]   stats_wc;
  logic [WEIGHT_W:0]   smooth_wc;

  assign cfg_ready = 1'b1;
  assign stats_wc  = 17'h10000 - {1'b0, stats_weight};
  assign smooth_wc = 17'h10000 - {1'b0, smooth_weight};

  always_ff @(posedge clk) begin
    if (rst) begin
      stats_weight  <= STATS_WEIGHT_RST;
      smooth_weight <= SMOOTH_WEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STATS_WEIGHT:  stats_weight  <= cfg_data;
        CFG_SMOOTH_WEIGHT: smooth_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  logic accept;

  assign adv         = !result_valid || !result_stall;
  assign coeff_stall = !adv;
  assign accept      = coeff_valid && adv;

  // frame position
  logic [PW-1:0] cnt;
  logic          stats_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      stats_valid <= 1'b0;
    end else if (accept) begin
      if (cnt == LAST_POS) begin
        cnt         <= '0;
        stats_valid <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // per-position stores
  logic signed [MEAN_W-1:0] mean_mem [NUM_FEATURES];
  logic [VAR_W-1:0]         var_mem  [NUM_FEATURES];
  logic signed [MEAN_W-1:0] sm_mem   [NUM_FEATURES];

  // stage 1: operands and stored statistics
  logic                      s1_v, s1_last, s1_first;
  logic [PW-1:0]             s1_p;
  logic signed [COEFF_W-1:0] s1_x;
  logic signed [MEAN_W-1:0]  s1_mean;
  logic [VAR_W-1:0]          s1_var;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= coeff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x     <= coeff;
      s1_p     <= cnt;
      s1_last  <= (cnt == LAST_POS);
      s1_first <= !stats_valid;
      s1_mean  <= mean_mem[cnt];
      s1_var   <= var_mem[cnt];
    end
  end

  // stage 2: weighted products, |x - mean|
  logic signed [MEAN_W:0]    s1_delta;
  logic                      s2_v, s2_last, s2_first;
  logic [PW-1:0]             s2_p;
  logic signed [COEFF_W-1:0] s2_x;
  logic signed [40:0]        s2_pm;
  logic signed [37:0]        s2_px;
  logic [63:0]               s2_pv;
  logic [MAG_W-1:0]          s2_d;

  assign s1_delta = $signed({{(MEAN_W+1-COEFF_W){s1_x[COEFF_W-1]}}, s1_x})
                  - $signed({s1_mean[MEAN_W-1], s1_mean});

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x     <= s1_x;
      s2_p     <= s1_p;
      s2_last  <= s1_last;
      s2_first <= s1_first;
      s2_pm    <= $signed({1'b0, stats_weight}) * s1_mean;
      s2_px    <= $signed({1'b0, stats_wc}) * s1_x;
      s2_pv    <= 64'(stats_weight * s1_var);
      s2_d     <= s1_delta[MEAN_W] ? MAG_W'(-s1_delta) : s1_delta[MAG_W-1:0];
    end
  end

  // stage 3: new mean, squared deviation
  logic signed [42:0]        s2_msum;
  logic signed [26:0]        s2_mrnd;
  logic                      s3_v, s3_last, s3_first;
  logic [PW-1:0]             s3_p;
  logic signed [COEFF_W-1:0] s3_x;
  logic signed [MEAN_W-1:0]  s3_mean;
  logic [VAR_W-1:0]          s3_sq;
  logic [63:0]               s3_pv;

  assign s2_msum = 43'(s2_pm) + 43'(s2_px) + 43'sd32768;
  assign s2_mrnd = 27'(s2_msum >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (adv) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_x     <= s2_x;
      s3_p     <= s2_p;
      s3_last  <= s2_last;
      s3_first <= s2_first;
      s3_mean  <= s2_first ? MEAN_W'(s2_x) : sat_q24(s2_mrnd);
      s3_sq    <= s2_d * s2_d;
      s3_pv    <= s2_pv;
    end
  end

  // stage 4: second variance product
  logic                      s4_v, s4_last, s4_first;
  logic [PW-1:0]             s4_p;
  logic signed [COEFF_W-1:0] s4_x;
  logic signed [MEAN_W-1:0]  s4_mean;
  logic [63:0]               s4_pv;
  logic [63:0]               s4_pd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (adv) begin
      s4_v <= s3_v;
    end
  end

  // weights sum to 2^16, so the weighted sum stays below 2^64
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_x     <= s3_x;
      s4_p     <= s3_p;
      s4_last  <= s3_last;
      s4_first <= s3_first;
      s4_mean  <= s3_mean;
      s4_pv    <= s3_pv;
      s4_pd    <= 64'(stats_wc * s3_sq);
    end
  end

  // stage 5: new variance, write back statistics, deviation for the divider
  logic [63:0]               s4_vt;
  logic [VAR_W-1:0]          s4_var;
  logic signed [MEAN_W:0]    s4_diff;
  logic                      s5_v, s5_last, s5_first, s5_neg;
  logic [PW-1:0]             s5_p;
  logic signed [COEFF_W-1:0] s5_x;
  logic [VAR_W-1:0]          s5_var;
  logic [MAG_W-1:0]          s5_mag;

  assign s4_vt   = s4_pv + s4_pd + 64'd32768;
  assign s4_var  = s4_first ? VAR_ONE : s4_vt[63:16];
  assign s4_diff = $signed({{(MEAN_W+1-COEFF_W){s4_x[COEFF_W-1]}}, s4_x})
                 - $signed({s4_mean[MEAN_W-1], s4_mean});

  always_ff @(posedge clk) begin
    if (adv && s4_v) begin
      mean_mem[s4_p] <= s4_mean;
      var_mem[s4_p]  <= s4_var;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (adv) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_x     <= s4_x;
      s5_p     <= s4_p;
      s5_last  <= s4_last;
      s5_first <= s4_first;
      s5_var   <= s4_var;
      s5_neg   <= s4_diff[MEAN_W];
      s5_mag   <= s4_diff[MEAN_W] ? MAG_W'(-s4_diff) : s4_diff[MAG_W-1:0];
    end
  end

  // square root of var + 1
  logic                 sq_v;
  logic [ROOT_W-1:0]    sq_root;
  logic [SB_SQ_W-1:0]   sq_sb;
  logic [RAD_W-1:0]     sq_rad;

  assign sq_rad = RAD_W'(s5_var) + RAD_W'(1);

  frn_sqrt #(
    .IN_W (RAD_W),
    .SB_W (SB_SQ_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s5_v),
    .radicand  (sq_rad),
    .in_sb     ({s5_x, s5_p, s5_last, s5_first, s5_neg, s5_mag}),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_sb    (sq_sb)
  );

  // |x - mean| * 2^10 / root
  logic               dv_v;
  logic [NUM_W-1:0]   dv_q;
  logic [SB_DV_W-1:0] dv_sb;

  frn_div #(
    .N_W  (NUM_W),
    .D_W  (ROOT_W),
    .SB_W (SB_DV_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_v),
    .dividend  ({sq_sb[MAG_W-1:0], {FRAC_W{1'b0}}}),
    .divisor   (sq_root),
    .in_sb     (sq_sb[SB_SQ_W-1:MAG_W]),
    .out_valid (dv_v),
    .quotient  (dv_q),
    .out_sb    (dv_sb)
  );

  // stage A: signed, saturated normalized value; fetch old smoothed value
  logic signed [COEFF_W-1:0] dv_x;
  logic [PW-1:0]             dv_p;
  logic                      dv_last, dv_first, dv_neg;
  logic [MAG_W-1:0]          dv_mag;
  logic signed [MEAN_W-1:0]  dv_norm;

  assign {dv_x, dv_p, dv_last, dv_first, dv_neg} = dv_sb;
  assign dv_mag  = (dv_q > NUM_W'(24'h800000)) ? 24'h800000 : dv_q[MAG_W-1:0];
  assign dv_norm = dv_neg ? MEAN_W'(-{1'b0, dv_mag})
                 : (dv_mag[MAG_W-1] ? 24'sh7FFFFF : dv_mag);

  logic                      a_v, a_last, a_first;
  logic [PW-1:0]             a_p;
  logic signed [COEFF_W-1:0] a_x;
  logic signed [MEAN_W-1:0]  a_norm;
  logic signed [MEAN_W-1:0]  a_sm_rd;
  logic signed [MEAN_W-1:0]  a_sm_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x     <= dv_x;
      a_p     <= dv_p;
      a_last  <= dv_last;
      a_first <= dv_first;
      a_norm  <= dv_norm;
      a_sm_rd <= sm_mem[dv_p];
    end
  end

  // first frame starts the smoothed value at the input itself
  assign a_sm_old = a_first ? MEAN_W'(a_x) : a_sm_rd;

  // stage B: smoothing products
  logic               b_v, b_last;
  logic [PW-1:0]      b_p;
  logic signed [40:0] b_ps;
  logic signed [41:0] b_pn;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_p    <= a_p;
      b_last <= a_last;
      b_ps   <= $signed({1'b0, smooth_weight}) * a_sm_old;
      b_pn   <= $signed({1'b0, smooth_wc}) * a_norm;
    end
  end

  // stage C: round, store smoothed state, output register
  logic signed [42:0]       b_sum;
  logic signed [MEAN_W-1:0] b_sm;

  assign b_sum = 43'(b_ps) + 43'(b_pn) + 43'sd32768;
  assign b_sm  = sat_q24(27'(b_sum >>> 16));

  always_ff @(posedge clk) begin
    if (adv && b_v) begin
      sm_mem[b_p] <= b_sm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (b_sm > 24'sd32767) begin
        smoothed_value <= 16'sh7FFF;
      end else if (b_sm < -24'sd32768) begin
        smoothed_value <= 16'sh8000;
      end else begin
        smoothed_value <= b_sm[OUT_W-1:0];
      end
      position  <= POS_W'(b_p);
      frame_end <= b_last;
    end
  end

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_POS)
    else $error("frame counter beyond last position");

  a_stats_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(stats_valid))
    else $error("first-frame flag set again without reset");

  a_first_frame_end: assert property (@(posedge clk) disable iff (rst)
    accept && (cnt == LAST_POS) |=> stats_valid && (cnt == '0))
    else $error("frame wrap did not end the first frame");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s5_var) && $stable(a_norm))
    else $error("pipeline moved while the output was stalled");

endmodule

// ===== tb/sv/feature_running_normalizer_tb.sv =====
`timescale 1ns / 1ps
// Testbench for feature_running_normalizer: a scoreboard predicts per-position EWMA stats.
// Depends on frn_pkg and the feature_running_normalizer RTL; stands alone otherwise.
module feature_running_normalizer_tb;
  import frn_pkg::*;

  localparam int NF = NUM_FEATURES_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT = 3000;

  logic clk;
  logic rst;
  logic coeff_valid;
  logic coeff_stall;
  logic signed [COEFF_W-1:0] coeff;
  logic result_valid;
  logic result_stall;
  logic signed [OUT_W-1:0] smoothed_value;
  logic [POS_W-1:0] position;
  logic frame_end;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  logic [WEIGHT_W-1:0] cfg_data;

  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic last;
  } norm_result_t;

  class norm_scoreboard;
    longint mean_q[NF];
    longint unsigned var_q[NF];
    longint smooth_q[NF];
    bit stats_ready;
    int unsigned slot;
    longint stats_w;
    longint smooth_w;
    norm_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned n_checked;

    function new();
      stats_ready = 0;
      slot = 0;
      stats_w = STATS_WEIGHT_RST;
      smooth_w = SMOOTH_WEIGHT_RST;
      mismatches = 0;
      n_checked = 0;
    endfunction

    function void set_weight(cfg_index_t idx, logic [WEIGHT_W-1:0] val);
      if (idx == CFG_STATS_WEIGHT) stats_w = val;
      else smooth_w = val;
    endfunction

    static function longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    // divide by 2^16, nearest, ties up
    static function longint round_q16(longint v);
      longint q;
      q = v >>> 16;
      if ((v & 64'hFFFF) >= 32768) q = q + 1;
      return q;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_coeff(logic signed [COEFF_W-1:0] c);
      longint x;
      longint delta;
      longint unsigned d2;
      longint unsigned vt;
      longint unsigned den;
      longint unsigned mag;
      longint diff;
      longint norm;
      longint sm;
      longint o;
      norm_result_t r;
      x = c;
      if (!stats_ready) begin
        mean_q[slot] = x;
        var_q[slot] = 64'd1048576;
        smooth_q[slot] = x;
      end else begin
        delta = x - mean_q[slot];
        d2 = (delta < 0) ? -delta : delta;
        d2 = d2 * d2;
        mean_q[slot] = clamp24(round_q16(stats_w * mean_q[slot] + (65536 - stats_w) * x));
        vt = stats_w * var_q[slot] + (65536 - stats_w) * d2 + 32768;
        var_q[slot] = (vt >> 16) & 64'hFFFF_FFFF_FFFF;
      end
      den = int_sqrt(var_q[slot] + 1);
      if (den == 0) den = 1;
      diff = x - mean_q[slot];
      mag = ((diff < 0) ? -diff : diff);
      mag = (mag << 10) / den;
      if (mag > 64'd8388608) mag = 64'd8388608;
      norm = clamp24((diff < 0) ? -longint'(mag) : longint'(mag));
      sm = clamp24(round_q16(smooth_w * smooth_q[slot] + (65536 - smooth_w) * norm));
      smooth_q[slot] = sm;
      o = sm;
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      r.value = o[OUT_W-1:0];
      r.pos = slot[POS_W-1:0];
      r.last = (slot == NF - 1);
      expected_q.push_back(r);
      if (r.last) begin
        stats_ready = 1;
        slot = 0;
      end else begin
        slot = slot + 1;
      end
    endfunction

    function void check_result(logic signed [OUT_W-1:0] v, logic [POS_W-1:0] p, logic fe);
      norm_result_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result value=%0d pos=%0d end=%0b", v, p, fe);
        return;
      end
      e = expected_q.pop_front();
      if (e.value !== v || e.pos !== p || e.last !== fe) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected value=%0d pos=%0d end=%0b, got %0d/%0d/%0b",
                   n_checked, e.value, e.pos, e.last, v, p, fe);
      end
    endfunction
  endclass

  norm_scoreboard sb;
  bit quiet_sink;
  bit quiet_source;
  int unsigned accepts;
  int unsigned n_sent;
  int unsigned n_cfg;
  longint base_val[NF];

  feature_running_normalizer u_top (
    .clk(clk), .rst(rst),
    .coeff_valid(coeff_valid), .coeff_stall(coeff_stall), .coeff(coeff),
    .result_valid(result_valid), .result_stall(result_stall),
    .smoothed_value(smoothed_value), .position(position), .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // result sink with random backpressure
  initial begin
    int n;
    result_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = quiet_sink ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      sb.check_result(smoothed_value, position, frame_end);
      accepts++;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((coeff_valid && !coeff_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("ERROR: timeout, no transaction for %0d cycles", idle);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_coeff(longint v);
    int gap;
    gap = quiet_source ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      coeff_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coeff_valid <= 1'b1;
    coeff <= v[COEFF_W-1:0];
    @(posedge clk);
    while (coeff_stall) @(posedge clk);
    sb.note_coeff(v[COEFF_W-1:0]);
    n_sent++;
  endtask

  // leaves cfg_valid high so writes can follow back to back; caller drops it
  task automatic write_cfg(cfg_index_t idx, logic [WEIGHT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_weight(idx, val);
    n_cfg++;
  endtask

  task automatic drain();
    coeff_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic longint pick_coeff(int p);
    int r;
    longint v;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      v = base_val[p] + $signed($urandom_range(0, 4096)) - 2048;
    end else if (r < 18) begin
      v = $signed($urandom_range(0, 1048575)) - 524288;
    end else begin
      v = (r == 18) ? 524287 : -524288;
    end
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v;
  endfunction

  initial begin
    static longint directed[25] = '{524287, -524288, 0, 1, -1, 1024, -1024, 524287, -524288,
                                    262144, -262144, 5, 0, -524288, 524287, 0, 1, -1, 524287,
                                    -524288, 1024, 2048, -4096, 100, -100};
    static logic [WEIGHT_W-1:0] sw[8] = '{STATS_WEIGHT_RST, 0, 65535, 0, 65535, 0, 0, 0};
    static logic [WEIGHT_W-1:0] mw[8] = '{SMOOTH_WEIGHT_RST, 0, 65535, 65535, 0, 0, 0, 0};
    int pos;
    sb = new();
    accepts = 0;
    n_sent = 0;
    n_cfg = 0;
    quiet_sink = 0;
    quiet_source = 0;
    rst <= 1'b1;
    coeff_valid <= 1'b0;
    coeff <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_STATS_WEIGHT;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first frame plus the start of the second, default weights
    foreach (directed[i]) send_coeff(directed[i]);
    pos = 25 % NF;

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph >= 5) begin
        sw[ph] = $urandom_range(0, 65535);
        mw[ph] = $urandom_range(0, 65535);
      end
      write_cfg(CFG_STATS_WEIGHT, sw[ph]);
      write_cfg(CFG_SMOOTH_WEIGHT, mw[ph]);
      cfg_valid <= 1'b0;
      foreach (base_val[i]) base_val[i] = $signed($urandom_range(0, 1048575)) - 524288;
      // stretches with and without idling, chosen at random
      for (int k = 0; k < 228; k++) begin
        if (k % 57 == 0) begin
          quiet_source = ($urandom_range(0, 3) == 0);
          quiet_sink = ($urandom_range(0, 3) == 0);
        end
        send_coeff(pick_coeff(pos));
        pos = (pos + 1) % NF;
      end
    end
    drain();
    quiet_sink = 0;

    $display("Summary: %0d coefficients sent, %0d results checked, %0d config writes,",
             n_sent, accepts, n_cfg);
    $display("  eight weight settings including both extremes; %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
